// ----- src/rarc_pkg.sv -----
// Shared types and constants for the random-access request controller.
// No dependencies; imported by rarc_core and random_access_request_control.
`default_nettype none

package rarc_pkg;

  localparam int unsigned CountWidth = 8;

  // Operation codes carried in func
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_RESPONSE = 2'd1;
  localparam logic [1:0] FUNC_GRANT    = 2'd2;
  localparam logic [1:0] FUNC_REPORT   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_RESPONSE_WINDOW = 1'b0;
  localparam logic CFG_MAX_ATTEMPTS    = 1'b1;

  localparam logic [CountWidth-1:0] RESPONSE_WINDOW_RESET = 8'd3;
  localparam logic [CountWidth-1:0] MAX_ATTEMPTS_RESET    = 8'd3;

  typedef struct packed {
    logic [1:0]            func;
    logic                  data_pending;
    logic                  pending_is_multicast;
    logic                  access_success;
    logic [CountWidth-1:0] backoff_draw;
  } item_t;

  typedef struct packed {
    logic                  request_issued;
    logic                  request_multicast;
    logic                  report_due_unicast;
    logic                  report_due_multicast;
    logic                  gave_up;
    logic [CountWidth-1:0] backoff_left;
    logic [CountWidth-1:0] attempts_made;
  } result_t;

endpackage

`default_nettype wire

// ----- src/rarc_core.sv -----
// Controller state and the single-pass update for one transaction.
// Depends on rarc_pkg for item_t, result_t and the operation codes.
`default_nettype none

module rarc_core import rarc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire item_t                 item,
  input  wire logic [CountWidth-1:0] response_window,
  input  wire logic [CountWidth-1:0] max_attempts,
  output result_t                    result
);

  logic [CountWidth-1:0] backoff_timer, backoff_timer_next;
  logic [CountWidth-1:0] window_timer, window_timer_next;
  logic                  unicast_requested, unicast_requested_next;
  logic                  multicast_requested, multicast_requested_next;
  logic [CountWidth-1:0] attempt_count, attempt_count_next;
  logic                  unicast_report_flag, unicast_report_flag_next;
  logic                  multicast_report_flag, multicast_report_flag_next;
  logic                  issued, issued_mc, quit;
  logic [CountWidth:0]   attempt_inc;

  assign attempt_inc = {1'b0, attempt_count} + {{CountWidth{1'b0}}, 1'b1};

  always_comb begin
    backoff_timer_next         = backoff_timer;
    window_timer_next          = window_timer;
    unicast_requested_next     = unicast_requested;
    multicast_requested_next   = multicast_requested;
    attempt_count_next         = attempt_count;
    unicast_report_flag_next   = unicast_report_flag;
    multicast_report_flag_next = multicast_report_flag;
    issued                     = 1'b0;
    issued_mc                  = 1'b0;
    quit                       = 1'b0;
    unique case (item.func)
      FUNC_TICK: begin
        if (backoff_timer != '0) begin
          backoff_timer_next = backoff_timer - 1'b1;
        end else if (window_timer != '0) begin
          window_timer_next = window_timer - 1'b1;
        end else if (unicast_requested) begin
          // response window expired: drop the outstanding request
          unicast_requested_next = 1'b0;
        end else if (multicast_requested) begin
          multicast_requested_next = 1'b0;
        end else if (item.data_pending) begin
          issued                   = 1'b1;
          issued_mc                = item.pending_is_multicast;
          unicast_requested_next   = !item.pending_is_multicast;
          multicast_requested_next = item.pending_is_multicast;
          window_timer_next        = response_window;
        end
      end
      FUNC_RESPONSE: begin
        if (item.access_success) begin
          if (multicast_requested) begin
            multicast_report_flag_next = 1'b1;
          end else begin
            unicast_report_flag_next = 1'b1;
          end
          attempt_count_next = '0;
          backoff_timer_next = '0;
        end else if (attempt_inc >= {1'b0, max_attempts}) begin
          // limit reached: give up and clear
          quit               = 1'b1;
          attempt_count_next = '0;
          backoff_timer_next = '0;
        end else begin
          attempt_count_next = attempt_inc[CountWidth-1:0];
          backoff_timer_next = item.backoff_draw;
        end
      end
      FUNC_GRANT: begin
        multicast_requested_next = 1'b0;
      end
      FUNC_REPORT: begin
        unicast_report_flag_next   = 1'b0;
        multicast_report_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.request_issued       = issued;
    result.request_multicast    = issued_mc;
    result.report_due_unicast   = unicast_report_flag_next;
    result.report_due_multicast = multicast_report_flag_next;
    result.gave_up              = quit;
    result.backoff_left         = backoff_timer_next;
    result.attempts_made        = attempt_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_timer         <= '0;
      window_timer          <= '0;
      unicast_requested     <= 1'b0;
      multicast_requested   <= 1'b0;
      attempt_count         <= '0;
      unicast_report_flag   <= 1'b0;
      multicast_report_flag <= 1'b0;
    end else if (advance) begin
      backoff_timer         <= backoff_timer_next;
      window_timer          <= window_timer_next;
      unicast_requested     <= unicast_requested_next;
      multicast_requested   <= multicast_requested_next;
      attempt_count         <= attempt_count_next;
      unicast_report_flag   <= unicast_report_flag_next;
      multicast_report_flag <= multicast_report_flag_next;
    end
  end

  // An issued request arms the response window and leaves one request flag set
  assert property (@(posedge clk) disable iff (rst)
    (advance && issued) |=> (window_timer == $past(response_window)) &&
      (unicast_requested != multicast_requested))
    else $error("request did not arm the response window");

  // A running backoff blocks every other tick action
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.func == FUNC_TICK && backoff_timer != '0) |=>
      (backoff_timer == $past(backoff_timer) - 1'b1) &&
      $stable(window_timer) && $stable(unicast_requested))
    else $error("tick during backoff did not only count down");

  // Giving up clears the attempt count and backoff
  assert property (@(posedge clk) disable iff (rst)
    (advance && quit) |=> (attempt_count == '0) && (backoff_timer == '0))
    else $error("give-up left attempt state behind");

endmodule

`default_nettype wire

// ----- src/random_access_request_control.sv -----
// Random-access request controller: input register, configuration registers,
// result register and handshake. Depends on rarc_pkg and rarc_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   tick, access response, grant received or status report sent. Output
//   channel (out_valid / out_stall) returns exactly one result per input.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data):
//   index 0 is the response window, index 1 the attempt limit. Write it only
//   while no transaction is in flight.
//   Timing: an accepted transaction is held in the input register; its result
//   is loaded into the output register once the output is free, raising
//   out_valid. Throughput: one transaction per cycle while the receiver
//   does not stall, with a combinational state update in rarc_core between
//   the input and result registers.
//   When the receiver stalls, the result holds; one more transaction is
//   taken into the input register, after which in_stall rises.
//   Reset clears all controller state and both valid flags and returns
//   the response window and attempt limit to 3.
`default_nettype none

module random_access_request_control import rarc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            func,
  input  wire logic                  data_pending,
  input  wire logic                  pending_is_multicast,
  input  wire logic                  access_success,
  input  wire logic [CountWidth-1:0] backoff_draw,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       request_issued,
  output logic                       request_multicast,
  output logic                       report_due_unicast,
  output logic                       report_due_multicast,
  output logic                       gave_up,
  output logic [CountWidth-1:0]      backoff_left,
  output logic [CountWidth-1:0]      attempts_made,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CountWidth-1:0] cfg_data
);

  logic [CountWidth-1:0] response_window;
  logic [CountWidth-1:0] max_attempts;
  logic                  item_valid;
  item_t                 item;
  result_t               core_result;
  result_t               result;
  logic                  advance;
  logic                  in_accept;

  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_window <= RESPONSE_WINDOW_RESET;
      max_attempts    <= MAX_ATTEMPTS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RESPONSE_WINDOW: response_window <= cfg_data;
        CFG_MAX_ATTEMPTS:    max_attempts    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item.func                 <= func;
      item.data_pending         <= data_pending;
      item.pending_is_multicast <= pending_is_multicast;
      item.access_success       <= access_success;
      item.backoff_draw         <= backoff_draw;
    end
  end

  rarc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (item),
    .response_window (response_window),
    .max_attempts    (max_attempts),
    .result          (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign request_issued       = result.request_issued;
  assign request_multicast    = result.request_multicast;
  assign report_due_unicast   = result.report_due_unicast;
  assign report_due_multicast = result.report_due_multicast;
  assign gave_up              = result.gave_up;
  assign backoff_left         = result.backoff_left;
  assign attempts_made        = result.attempts_made;

  // Input side only stalls when both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // A blocked result transaction is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(result))
    else $error("stalled result changed");

  // A held item always moves on once the output frees up
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_valid) |-> advance)
    else $error("item held with empty output stage");

endmodule

`default_nettype wire
